FILE: hw/rtl/cchu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cchu_pkg: shared definitions for the cyclic code weight histogram unit
// Widths, opcodes, the queued item type, row rotation and ones-count helpers.
// ----------------------------------------------------------------------------
package cchu_pkg;

  localparam int unsigned CodeLength   = 64;
  localparam int unsigned RowCount     = 32;
  localparam int unsigned GenWidth     = 33;
  localparam int unsigned BinDepth     = CodeLength + 1;
  localparam int unsigned BinAddrWidth = $clog2(BinDepth);
  localparam int unsigned WeightWidth  = $clog2(CodeLength + 1);
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned ByteCount    = CodeLength / 8;
  localparam int unsigned ShiftWidth   = $clog2(CodeLength);
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  localparam logic [GenWidth-1:0]   GenReset = 33'h1_F192_2815;
  localparam logic [CountWidth-1:0] BinMax   = {CountWidth{1'b1}};

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]              op;
    logic [BinAddrWidth-1:0] bin_index;
    logic [CodeLength-1:0]   codeword;
    logic [WeightWidth-1:0]  weight;
  } item_t;

  function automatic logic [CodeLength-1:0] rotate_row(input logic [CodeLength-1:0] w,
                                                       input logic [ShiftWidth-1:0] s);
    logic [2*CodeLength-1:0] dbl;
    dbl = {w, w} >> s;
    return dbl[CodeLength-1:0];
  endfunction

  function automatic logic [3:0] ones_in_byte(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, b[k]};
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/cyclic_code_weight_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_code_weight_histogram_unit: weight histogram of a cyclic code
// Builds codewords from rotations of a generator word and keeps a
// saturating histogram of their weights.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per item:
//   count a subset, read a bin or clear all bins. Each request gives one
//   result on the output channel (out_valid_o / out_stall_i), in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes the 33-bit
//   generator word; ready is always high, write only while idle.
//   Throughput: one request per cycle, sustained while out_stall_i is low,
//   set by the one-read one-write bin memory read-modify-write with
//   last-write forwarding. Path: a request passes two front stages, the
//   queue, the bin read stage and the result register.
//   Reset: generator returns to its reset value and every bin reads zero
//   at once through per-bin valid bits; no clearing pass is needed.
//   Receiver stall: the result register holds, the back stops, the four
//   entry queue fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
module cyclic_code_weight_histogram_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cchu_pkg::GenWidth-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         in_opcode_i,
  input  logic [cchu_pkg::RowCount-1:0]      in_subset_mask_i,
  input  logic [cchu_pkg::BinAddrWidth-1:0]  in_bin_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cchu_pkg::CodeLength-1:0]    out_codeword_o,
  output logic [cchu_pkg::WeightWidth-1:0]   out_codeword_weight_o,
  output logic [cchu_pkg::CountWidth-1:0]    out_bin_count_o
);

  logic [cchu_pkg::GenWidth-1:0] gen_q;
  logic                          push, full, pop, q_vld;
  cchu_pkg::item_t               push_item, pop_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= cchu_pkg::GenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gen_q <= cfg_data_i;
    end
  end

  cchu_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .gen_i            (gen_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_opcode_i      (in_opcode_i),
    .in_subset_mask_i (in_subset_mask_i),
    .in_bin_index_i   (in_bin_index_i),
    .push_o           (push),
    .push_item_o      (push_item),
    .full_i           (full)
  );

  cchu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .vld_o       (q_vld),
    .pop_item_o  (pop_item)
  );

  cchu_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .q_vld_i               (q_vld),
    .q_item_i              (pop_item),
    .pop_o                 (pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_codeword_o        (out_codeword_o),
    .out_codeword_weight_o (out_codeword_weight_o),
    .out_bin_count_o       (out_bin_count_o)
  );

endmodule

FILE: hw/rtl/cchu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cchu_front: request intake and codeword build
// Takes requests, XORs the selected generator rotations, counts the ones in
// two registered steps and hands finished items to the queue.
// ----------------------------------------------------------------------------
module cchu_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [cchu_pkg::GenWidth-1:0]       gen_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          in_opcode_i,
  input  logic [cchu_pkg::RowCount-1:0]       in_subset_mask_i,
  input  logic [cchu_pkg::BinAddrWidth-1:0]   in_bin_index_i,
  output logic                                push_o,
  output cchu_pkg::item_t                     push_item_o,
  input  logic                                full_i
);

  logic                                    f1_vld_q;
  logic [1:0]                              f1_op_q;
  logic [cchu_pkg::BinAddrWidth-1:0]       f1_idx_q;
  logic [cchu_pkg::CodeLength-1:0]         f1_cw_q;
  logic [cchu_pkg::CodeLength-1:0]         cw_d;

  logic                                    f2_vld_q;
  logic [1:0]                              f2_op_q;
  logic [cchu_pkg::BinAddrWidth-1:0]       f2_idx_q;
  logic [cchu_pkg::CodeLength-1:0]         f2_cw_q;
  logic [cchu_pkg::ByteCount-1:0][3:0]     f2_part_q;
  logic [cchu_pkg::ByteCount-1:0][3:0]     part_d;
  logic [cchu_pkg::WeightWidth-1:0]        weight;

  logic f2_adv, f1_adv, accept;

  assign f2_adv     = f2_vld_q && !full_i;
  assign f1_adv     = f1_vld_q && (!f2_vld_q || f2_adv);
  assign accept     = in_valid_i && (!f1_vld_q || f1_adv);
  assign in_stall_o = f1_vld_q && !f1_adv;

  always_comb begin
    logic [cchu_pkg::CodeLength-1:0] base;
    base = cchu_pkg::CodeLength'(gen_i);
    cw_d = '0;
    for (int j = 0; j < cchu_pkg::RowCount; j++) begin
      if (in_subset_mask_i[j]) begin
        cw_d = cw_d ^ cchu_pkg::rotate_row(base, cchu_pkg::ShiftWidth'(j));
      end
    end
  end

  always_comb begin
    for (int b = 0; b < cchu_pkg::ByteCount; b++) begin
      part_d[b] = cchu_pkg::ones_in_byte(f1_cw_q[8*b +: 8]);
    end
  end

  always_comb begin
    weight = '0;
    for (int b = 0; b < cchu_pkg::ByteCount; b++) begin
      weight = weight + cchu_pkg::WeightWidth'(f2_part_q[b]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        f1_vld_q <= 1'b1;
      end else if (f1_adv) begin
        f1_vld_q <= 1'b0;
      end
      if (f1_adv) begin
        f2_vld_q <= 1'b1;
      end else if (f2_adv) begin
        f2_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_op_q  <= in_opcode_i;
      f1_idx_q <= in_bin_index_i;
      f1_cw_q  <= cw_d;
    end
    if (f1_adv) begin
      f2_op_q   <= f1_op_q;
      f2_idx_q  <= f1_idx_q;
      f2_cw_q   <= f1_cw_q;
      f2_part_q <= part_d;
    end
  end

  assign push_o                = f2_adv;
  assign push_item_o.op        = f2_op_q;
  assign push_item_o.bin_index = f2_idx_q;
  assign push_item_o.codeword  = f2_cw_q;
  assign push_item_o.weight    = weight;

endmodule

FILE: hw/rtl/cchu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cchu_queue: item queue between front and back
// Small circular buffer that lets the two halves stall independently.
// ----------------------------------------------------------------------------
module cchu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cchu_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            vld_o,
  output cchu_pkg::item_t pop_item_o
);

  cchu_pkg::item_t                       entry_q [cchu_pkg::QueueDepth];
  logic [cchu_pkg::QueuePtrWidth-1:0]    wr_ptr_q, rd_ptr_q;
  logic [cchu_pkg::QueuePtrWidth:0]      cnt_q;

  assign full_o     = (cnt_q == (cchu_pkg::QueuePtrWidth+1)'(cchu_pkg::QueueDepth));
  assign vld_o      = (cnt_q != '0);
  assign pop_item_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/cchu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cchu_back: histogram update and result register
// Reads the bin, updates it with saturation, forwards the last write over a
// read in flight, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module cchu_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_vld_i,
  input  cchu_pkg::item_t                    q_item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cchu_pkg::CodeLength-1:0]    out_codeword_o,
  output logic [cchu_pkg::WeightWidth-1:0]   out_codeword_weight_o,
  output logic [cchu_pkg::CountWidth-1:0]    out_bin_count_o
);

  logic [cchu_pkg::CountWidth-1:0]   mem_q [cchu_pkg::BinDepth];
  logic [cchu_pkg::BinDepth-1:0]     bin_vld_q;
  logic [cchu_pkg::CountWidth-1:0]   rd_data_q;

  logic                              a_vld_q;
  cchu_pkg::item_t                   a_item_q;
  logic [cchu_pkg::BinAddrWidth-1:0] a_addr_q;
  logic                              a_inrange_q;

  logic                              fwd_vld_q;
  logic [cchu_pkg::BinAddrWidth-1:0] fwd_addr_q;
  logic [cchu_pkg::CountWidth-1:0]   fwd_data_q;

  logic                              out_vld_q;
  logic [cchu_pkg::CodeLength-1:0]   out_cw_q;
  logic [cchu_pkg::WeightWidth-1:0]  out_wt_q;
  logic [cchu_pkg::CountWidth-1:0]   out_bin_q;

  logic                              fire;
  logic [cchu_pkg::BinAddrWidth-1:0] rd_addr;
  logic                              rd_inrange;
  logic [cchu_pkg::CountWidth-1:0]   old_val, inc_val;
  logic                              wr_en, clr_en;
  logic [cchu_pkg::CodeLength-1:0]   cw_d;
  logic [cchu_pkg::WeightWidth-1:0]  wt_d;
  logic [cchu_pkg::CountWidth-1:0]   bin_d;

  assign fire  = a_vld_q && (!out_vld_q || !out_stall_i);
  assign pop_o = q_vld_i && (!a_vld_q || fire);

  always_comb begin
    if (q_item_i.op == cchu_pkg::OP_COUNT) begin
      rd_addr    = cchu_pkg::BinAddrWidth'(q_item_i.weight);
      rd_inrange = 1'b1;
    end else begin
      rd_inrange = (q_item_i.bin_index <= cchu_pkg::BinAddrWidth'(cchu_pkg::CodeLength));
      rd_addr    = rd_inrange ? q_item_i.bin_index : '0;
    end
  end

  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == a_addr_q)) begin
      old_val = fwd_data_q;
    end else if (bin_vld_q[a_addr_q]) begin
      old_val = rd_data_q;
    end else begin
      old_val = '0;
    end
    inc_val = (old_val == cchu_pkg::BinMax) ? old_val : old_val + 1'b1;
  end

  always_comb begin
    wr_en  = 1'b0;
    clr_en = 1'b0;
    cw_d   = '0;
    wt_d   = '0;
    bin_d  = '0;
    unique case (a_item_q.op)
      cchu_pkg::OP_COUNT: begin
        wr_en = fire;
        cw_d  = a_item_q.codeword;
        wt_d  = a_item_q.weight;
        bin_d = inc_val;
      end
      cchu_pkg::OP_READ: begin
        bin_d = a_inrange_q ? old_val : '0;
      end
      cchu_pkg::OP_CLEAR: begin
        clr_en = fire;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_vld_q <= 1'b0;
      bin_vld_q <= '0;
    end else begin
      if (pop_o) begin
        a_vld_q <= 1'b1;
      end else if (fire) begin
        a_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (clr_en) begin
        fwd_vld_q <= 1'b0;
        bin_vld_q <= '0;
      end else if (wr_en) begin
        fwd_vld_q           <= 1'b1;
        bin_vld_q[a_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_item_q    <= q_item_i;
      a_addr_q    <= rd_addr;
      a_inrange_q <= rd_inrange;
      rd_data_q   <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[a_addr_q] <= inc_val;
      fwd_addr_q      <= a_addr_q;
      fwd_data_q      <= inc_val;
    end
    if (fire) begin
      out_cw_q  <= cw_d;
      out_wt_q  <= wt_d;
      out_bin_q <= bin_d;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign out_codeword_o        = out_cw_q;
  assign out_codeword_weight_o = out_wt_q;
  assign out_bin_count_o       = out_bin_q;

endmodule

FILE: tb/tb_cyclic_code_weight_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cyclic_code_weight_histogram_unit: self-checking bench for the histogram
// Drives count, read, clear and unused requests under random idling on both
// channels. A local model of the generator rows and the weight bins predicts
// every result, and each accepted result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_cyclic_code_weight_histogram_unit;
  import cchu_pkg::*;

  localparam logic [1:0]          OpUnused    = 2'd3;
  localparam int unsigned         CycleLimit  = 600000;
  localparam int unsigned         DrainCycles = 12;
  localparam int unsigned         RandomItems = 1500;
  localparam int unsigned         MaxReports  = 100;
  localparam logic [GenWidth-1:0] GenAllOnes  = {GenWidth{1'b1}};

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SOME,
    IDLE_HEAVY
  } idle_mode_e;

  typedef struct packed {
    logic [CodeLength-1:0]  codeword;
    logic [WeightWidth-1:0] weight;
    logic [CountWidth-1:0]  bin_count;
  } histo_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [GenWidth-1:0]     cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              in_opcode_i;
  logic [RowCount-1:0]     in_subset_mask_i;
  logic [BinAddrWidth-1:0] in_bin_index_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [CodeLength-1:0]   out_codeword_o;
  logic [WeightWidth-1:0]  out_codeword_weight_o;
  logic [CountWidth-1:0]   out_bin_count_o;

  logic [GenWidth-1:0]     gen_word;
  logic [CountWidth-1:0]   weight_bin_model [BinDepth];
  histo_result_t           expected_results [$];
  idle_mode_e              idle_mode = IDLE_NONE;
  int unsigned             stall_left = 0;
  int unsigned             cycle_count = 0;
  int unsigned             error_count = 0;
  int unsigned             results_checked = 0;
  int unsigned             count_reqs = 0;
  int unsigned             read_reqs = 0;
  int unsigned             clear_reqs = 0;
  int unsigned             unused_reqs = 0;
  int unsigned             gen_writes = 0;

  cyclic_code_weight_histogram_unit dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_opcode_i           (in_opcode_i),
    .in_subset_mask_i      (in_subset_mask_i),
    .in_bin_index_i        (in_bin_index_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_codeword_o        (out_codeword_o),
    .out_codeword_weight_o (out_codeword_weight_o),
    .out_bin_count_o       (out_bin_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_mode == IDLE_NONE) return 0;
    if (idle_mode == IDLE_SOME) begin
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
    end
    if (r < 40) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [RowCount-1:0] random_mask();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return RowCount'(1) << $urandom_range(0, RowCount - 1);
      3: return $urandom & $urandom;
      4: return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GenWidth-1:0] random_generator();
    return {1'($urandom), 32'($urandom)};
  endfunction

  // Updates the bin model as a side effect, so call once per accepted request.
  function automatic histo_result_t predict_histogram(input logic [1:0] op,
                                                      input logic [RowCount-1:0] mask,
                                                      input logic [BinAddrWidth-1:0] idx);
    histo_result_t         r;
    logic [CodeLength-1:0] base;
    int unsigned           w;
    r    = '0;
    base = {{(CodeLength - GenWidth){1'b0}}, gen_word};
    case (op)
      OP_COUNT: begin
        for (int j = 0; j < RowCount; j++) begin
          if (mask[j]) r.codeword ^= (base >> j) | (base << (CodeLength - j));
        end
        w = $countones(r.codeword);
        if (weight_bin_model[w] != BinMax) weight_bin_model[w]++;
        r.weight    = WeightWidth'(w);
        r.bin_count = weight_bin_model[w];
      end
      OP_READ: begin
        if (idx < BinDepth) r.bin_count = weight_bin_model[idx];
      end
      OP_CLEAR: begin
        foreach (weight_bin_model[i]) weight_bin_model[i] = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : drive_out_stall
    logic nxt;
    nxt = 1'b0;
    if (stall_left != 0) begin
      stall_left--;
      nxt = 1'b1;
    end else begin
      stall_left = pick_gap();
      if (stall_left != 0) begin
        stall_left--;
        nxt = 1'b1;
      end
    end
    out_stall_i <= nxt;
  end

  always @(posedge clk_i) begin : check_results
    histo_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, codeword %h",
                                  out_codeword_o));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_codeword_o !== want.codeword)
          report_mismatch($sformatf("result %0d codeword %h, expected %h", results_checked,
                                    out_codeword_o, want.codeword));
        if (out_codeword_weight_o !== want.weight)
          report_mismatch($sformatf("result %0d weight %0d, expected %0d", results_checked,
                                    out_codeword_weight_o, want.weight));
        if (out_bin_count_o !== want.bin_count)
          report_mismatch($sformatf("result %0d bin count %0d, expected %0d",
                                    results_checked, out_bin_count_o, want.bin_count));
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [RowCount-1:0] mask,
                              input logic [BinAddrWidth-1:0] idx);
    int unsigned gap;
    in_valid_i       <= 1'b1;
    in_opcode_i      <= op;
    in_subset_mask_i <= mask;
    in_bin_index_i   <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(predict_histogram(op, mask, idx));
    case (op)
      OP_COUNT: count_reqs++;
      OP_READ:  read_reqs++;
      OP_CLEAR: clear_reqs++;
      default:  unused_reqs++;
    endcase
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_generator(input logic [GenWidth-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gen_word = value;
    gen_writes++;
  endtask

  task automatic send_random_request();
    int unsigned             pick;
    logic [BinAddrWidth-1:0] idx;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) idx = BinAddrWidth'($urandom);
    else idx = BinAddrWidth'($urandom_range(0, CodeLength));
    if (pick < 72) send_request(OP_COUNT, random_mask(), idx);
    else if (pick < 97) send_request(OP_READ, random_mask(), idx);
    else if (pick < 98) send_request(OP_CLEAR, random_mask(), idx);
    else send_request(OpUnused, random_mask(), idx);
  endtask

  task automatic test_directed();
    idle_mode = IDLE_NONE;
    send_request(OP_READ, '0, 7'd0);
    send_request(OP_COUNT, '0, '0);
    send_request(OP_COUNT, '1, '1);
    send_request(OP_COUNT, 32'h8000_0000, '0);
    send_request(OP_COUNT, 32'h0000_0001, '0);
    send_request(OP_COUNT, 32'h8000_0001, '0);
    send_request(OP_COUNT, 32'h5555_5555, '0);
    send_request(OP_COUNT, 32'hAAAA_AAAA, '0);
    send_request(OP_COUNT, '0, '0);
    send_request(OP_READ, '1, 7'd0);
    send_request(OP_READ, '0, 7'd64);
    send_request(OP_READ, '0, 7'd65);
    send_request(OP_READ, '0, 7'd127);
    send_request(OpUnused, '1, 7'd0);
    send_request(OpUnused, '0, '1);
    send_request(OP_CLEAR, '1, '1);
    send_request(OP_READ, '0, 7'd0);
    send_request(OP_COUNT, 32'h0000_FFFF, 7'd0);
    write_generator(GenAllOnes);
    send_request(OP_COUNT, 32'h0000_0001, '0);
    send_request(OP_COUNT, 32'hFFFF_FFFF, '0);
    send_request(OP_COUNT, 32'h8000_0000, '0);
    send_request(OP_READ, '0, 7'd33);
    send_request(OP_READ, '0, 7'd64);
  endtask

  task automatic test_generator_extremes();
    logic [GenWidth-1:0] settings [6];
    settings = '{GenWidth'(0), GenWidth'(1), GenWidth'(1) << 32, GenAllOnes, GenReset,
                 random_generator()};
    idle_mode = IDLE_SOME;
    foreach (settings[s]) begin
      write_generator(settings[s]);
      repeat (10) send_request(OP_COUNT, random_mask(), BinAddrWidth'($urandom));
      send_request(OP_READ, '0, 7'd0);
      send_request(OP_READ, '0, BinAddrWidth'($urandom_range(0, CodeLength)));
    end
  endtask

  task automatic test_random_traffic();
    for (int unsigned n = 0; n < RandomItems; n++) begin
      case (n % 300)
        0:   idle_mode = IDLE_SOME;
        100: idle_mode = IDLE_NONE;
        200: idle_mode = IDLE_HEAVY;
        default: begin
        end
      endcase
      if (n == 500 || n == 1000) write_generator(random_generator());
      if (n == 750) drain_results();
      send_random_request();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    in_opcode_i      = OP_COUNT;
    in_subset_mask_i = '0;
    in_bin_index_i   = '0;
    gen_word         = GenReset;
    foreach (weight_bin_model[i]) weight_bin_model[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    test_directed();
    test_generator_extremes();
    test_random_traffic();
    drain_results();

    $display("Checked %0d results: %0d count, %0d read, %0d clear, %0d unused-opcode requests",
             results_checked, count_reqs, read_reqs, clear_reqs, unused_reqs);
    $display("Generator word written %0d times, zero and all-ones words among them",
             gen_writes);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: cyclic_code_weight_histogram_unit.f
hw/rtl/cchu_pkg.sv
hw/rtl/cchu_front.sv
hw/rtl/cchu_queue.sv
hw/rtl/cchu_back.sv
hw/rtl/cyclic_code_weight_histogram_unit.sv
tb/tb_cyclic_code_weight_histogram_unit.sv
